/* hdl/ssa_pkg.sv */
// Shared constants, word types and the exp2 table for the shaped sigmoid unit.
package ssa_pkg;

    // Number format
    localparam int FRAC_BITS     = 16;
    localparam int LUT_ADDR_BITS = 8;
    localparam int DATA_W        = 24;

    // Front end widths
    localparam int DIFF_W  = DATA_W + 2;          // 2*x - min - max
    localparam int Z_W     = DATA_W + DIFF_W;     // shape * diff
    localparam int Q24_W   = 30;                  // clamped |z| in Q24, at most 32.0
    localparam int LOG2E_W = 31;
    localparam int UP_W    = Q24_W + LOG2E_W;     // |z| * log2(e)
    localparam int U_W     = 30;                  // u in Q24
    localparam int N_W     = U_W - 24;            // integer part of u

    // |z| carries 2*FRAC_BITS+1 fraction bits; realign it to Q24
    localparam int          SHIFT_Z = 2 * FRAC_BITS + 1;
    localparam logic [63:0] Z_LIMIT = 64'd32 << SHIFT_Z;
    localparam int          Z_SHR   = (SHIFT_Z >= 24) ? SHIFT_Z - 24 : 0;
    localparam int          Z_SHL   = (SHIFT_Z >= 24) ? 0 : 24 - SHIFT_Z;

    // exp2 widths
    localparam int REM_W    = 24 - LUT_ADDR_BITS;
    localparam int CP_W     = REM_W + 30;         // rem * ln2
    localparam int CORR_W   = CP_W - 24;
    localparam int P_W      = 31;                 // Q30 values up to 1.0
    localparam int LUT_SIZE = 1 << LUT_ADDR_BITS;
    localparam logic [N_W-1:0] SHIFT_FLUSH = N_W'(31);

    // Divider: floor(2^60 / (2^30 + e))
    localparam int DEN_W         = 32;
    localparam int Q_W           = 31;
    localparam int DIV_STEPS     = Q_W;
    localparam int DIV_PER_STAGE = 4;
    localparam int DIV_STAGES    = (DIV_STEPS + DIV_PER_STAGE - 1) / DIV_PER_STAGE;

    // Back end widths
    localparam int B_W   = 31;                    // second multiplier operand
    localparam int MUL_W = DATA_W + B_W;

    // Fixed-point constants
    localparam logic [LOG2E_W-1:0]          LOG2E_Q30 = 31'd1549082005;
    localparam logic [29:0]                 LN2_Q30   = 30'd744261118;
    localparam logic [P_W-1:0]              Q30_ONE   = 31'h4000_0000;
    localparam logic signed [DIFF_W-1:0]    ONE_FX    = DIFF_W'(64'd1 << FRAC_BITS);

    // Rounding shifts and half-LSB constants
    localparam int RS_SIG = 30 - FRAC_BITS;
    localparam int RS_SPC = FRAC_BITS;
    localparam int RS_GEN = 30;
    localparam logic [MUL_W-1:0] HALF_SIG = MUL_W'(1) << (RS_SIG - 1);
    localparam logic [MUL_W-1:0] HALF_SPC = MUL_W'(1) << (RS_SPC - 1);
    localparam logic [MUL_W-1:0] HALF_GEN = MUL_W'(1) << (RS_GEN - 1);

    // Saturation limits
    localparam logic [MUL_W-1:0]         MAG_POS_LIMIT = MUL_W'(64'd1 << (DATA_W - 1)) - 1'b1;
    localparam logic [MUL_W-1:0]         MAG_NEG_LIMIT = MUL_W'(64'd1 << (DATA_W - 1));
    localparam logic signed [DATA_W-1:0] RES_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] RES_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // Configuration register indexes and reset values
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SHAPE_GAIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MIN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MAX  = 2'd2;
    localparam logic signed [DATA_W-1:0] SHAPE_GAIN_RESET = 24'sd65536;
    localparam logic signed [DATA_W-1:0] RANGE_MIN_RESET  = 24'sd0;
    localparam logic signed [DATA_W-1:0] RANGE_MAX_RESET  = 24'sd65536;

    // Final rounding selector
    typedef enum logic [1:0] {
        RND_SIGMA,
        RND_SPECIAL,
        RND_GENERAL
    } t_rnd;

    // Per-word side information that rides along the whole pipe
    typedef struct packed {
        logic                     func;
        logic                     special;   // derivative with range -1..1 and unit shape
        logic                     neg;       // z below zero
        logic signed [DATA_W-1:0] opa;       // value for the special case, else shape
    } t_side;

    typedef struct packed {
        logic [U_W-1:0] u;
        t_side          side;
    } t_fe_word;

    typedef struct packed {
        logic [DEN_W-1:0] den;
        t_side            side;
    } t_ed_word;

    typedef struct packed {
        logic [Q_W-1:0] quo;
        logic           rem_nz;
        t_side          side;
    } t_dq_word;

    typedef logic [P_W-1:0] t_lut [LUT_SIZE];

    // Integer square root, bit by bit
    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] rest;
        logic [63:0] root;
        logic [63:0] bitv;
        rest = v;
        root = '0;
        for (int i = 0; i < 32; i++) begin
            bitv = 64'd1 << (62 - 2 * i);
            if (rest >= root + bitv) begin
                rest = rest - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
        end
        return root;
    endfunction

    // Products of 2^(-1/2^j) factors, one entry per top-fraction pattern
    function automatic t_lut build_lut();
        t_lut        tbl;
        logic [63:0] fac [LUT_ADDR_BITS];
        logic [63:0] c;
        logic [63:0] p;
        c = 64'd1 << 29;
        for (int j = 0; j < LUT_ADDR_BITS; j++) begin
            c = isqrt64(c << 30);
            fac[j] = c;
        end
        for (int k = 0; k < LUT_SIZE; k++) begin
            p = 64'd1 << 30;
            for (int j = 0; j < LUT_ADDR_BITS; j++) begin
                if (k[LUT_ADDR_BITS-1-j]) begin
                    p = (p * fac[j]) >> 30;
                end
            end
            tbl[k] = p[P_W-1:0];
        end
        return tbl;
    endfunction

    localparam t_lut EXP2_LUT = build_lut();

endpackage

/* hdl/ssa_front.sv */
// Front pipe: centering, shape multiply, clamp and scale by log2(e).
module ssa_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic                             i_func,
    input  logic signed [ssa_pkg::DATA_W-1:0] i_value,
    input  logic signed [ssa_pkg::DATA_W-1:0] i_shape_gain,
    input  logic signed [ssa_pkg::DATA_W-1:0] i_range_min,
    input  logic signed [ssa_pkg::DATA_W-1:0] i_range_max,
    output logic                             o_valid,
    input  logic                             i_ready,
    output ssa_pkg::t_fe_word                o_word
);

    localparam int NST = 4;

    logic [NST-1:0] r_vld;
    logic [NST-1:0] n_vld;
    logic [NST:0]   rdy;

    logic signed [ssa_pkg::DIFF_W-1:0] x_e;
    logic signed [ssa_pkg::DIFF_W-1:0] lo_e;
    logic signed [ssa_pkg::DIFF_W-1:0] hi_e;
    logic signed [ssa_pkg::DIFF_W-1:0] sg_e;
    logic signed [ssa_pkg::DIFF_W-1:0] n_s1_diff;
    logic signed [ssa_pkg::DIFF_W-1:0] r_s1_diff;
    logic signed [ssa_pkg::DATA_W-1:0] r_s1_shp;
    ssa_pkg::t_side                    n_s1_side;
    ssa_pkg::t_side                    r_s1_side;

    logic signed [ssa_pkg::Z_W-1:0]    n_s2_z;
    logic signed [ssa_pkg::Z_W-1:0]    r_s2_z;
    ssa_pkg::t_side                    r_s2_side;

    logic [ssa_pkg::Z_W-1:0]           z_mag;
    logic [63:0]                       z_clamp;
    logic [63:0]                       a_wide;
    logic [ssa_pkg::Q24_W-1:0]         r_s3_a;
    ssa_pkg::t_side                    n_s3_side;
    ssa_pkg::t_side                    r_s3_side;

    logic [ssa_pkg::UP_W-1:0]          u_prod;
    logic [ssa_pkg::U_W-1:0]           r_s4_u;
    ssa_pkg::t_side                    r_s4_side;

    // Stage handshake: a stage takes a word when it is empty or its word moves on
    assign rdy[NST] = i_ready;
    for (genvar k = 0; k < NST; k++) begin : g_rdy
        assign rdy[k] = !r_vld[k] || rdy[k+1];
    end
    assign n_vld   = {r_vld[NST-2:0], i_valid};
    assign o_ready = rdy[0];
    assign o_valid = r_vld[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NST; k++) begin
                if (rdy[k]) begin
                    r_vld[k] <= n_vld[k];
                end
            end
        end
    end

    // Stage 1: 2*x - min - max and the special derivative mode
    always_comb begin
        x_e  = ssa_pkg::DIFF_W'(i_value);
        lo_e = ssa_pkg::DIFF_W'(i_range_min);
        hi_e = ssa_pkg::DIFF_W'(i_range_max);
        sg_e = ssa_pkg::DIFF_W'(i_shape_gain);
        n_s1_diff = (x_e <<< 1) - lo_e - hi_e;
        n_s1_side.func    = i_func;
        n_s1_side.special = i_func && (lo_e == -ssa_pkg::ONE_FX)
                            && (hi_e == ssa_pkg::ONE_FX) && (sg_e == ssa_pkg::ONE_FX);
        n_s1_side.neg     = 1'b0;
        n_s1_side.opa     = n_s1_side.special ? i_value : i_shape_gain;
    end

    // Stage 2: z = shape * diff
    assign n_s2_z = r_s1_shp * r_s1_diff;

    // Stage 3: magnitude, clamp to 32.0, realign to Q24
    always_comb begin
        z_mag   = r_s2_z[ssa_pkg::Z_W-1] ? -r_s2_z : r_s2_z;
        z_clamp = (64'(z_mag) > ssa_pkg::Z_LIMIT) ? ssa_pkg::Z_LIMIT : 64'(z_mag);
        a_wide  = (z_clamp >> ssa_pkg::Z_SHR) << ssa_pkg::Z_SHL;
        n_s3_side     = r_s2_side;
        n_s3_side.neg = r_s2_z[ssa_pkg::Z_W-1];
    end

    // Stage 4: u = a * log2(e), Q24
    assign u_prod = ssa_pkg::UP_W'(r_s3_a) * ssa_pkg::UP_W'(ssa_pkg::LOG2E_Q30);

    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            r_s1_diff <= n_s1_diff;
            r_s1_shp  <= i_shape_gain;
            r_s1_side <= n_s1_side;
        end
        if (rdy[1]) begin
            r_s2_z    <= n_s2_z;
            r_s2_side <= r_s1_side;
        end
        if (rdy[2]) begin
            r_s3_a    <= a_wide[ssa_pkg::Q24_W-1:0];
            r_s3_side <= n_s3_side;
        end
        if (rdy[3]) begin
            r_s4_u    <= u_prod[ssa_pkg::U_W+29:30];
            r_s4_side <= r_s3_side;
        end
    end

    assign o_word.u    = r_s4_u;
    assign o_word.side = r_s4_side;

endmodule

/* hdl/ssa_exp2.sv */
// exp2 pipe: table lookup, linear correction and integer shift into 1 + e^-|z|.
module ssa_exp2 (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  ssa_pkg::t_fe_word i_word,
    output logic              o_valid,
    input  logic              i_ready,
    output ssa_pkg::t_ed_word o_word
);

    localparam int NST = 3;

    logic [NST-1:0] r_vld;
    logic [NST-1:0] n_vld;
    logic [NST:0]   rdy;

    logic [ssa_pkg::LUT_ADDR_BITS-1:0] idx;
    logic [ssa_pkg::REM_W-1:0]         frac_rem;
    logic [ssa_pkg::CP_W-1:0]          corr_prod;
    logic [ssa_pkg::P_W-1:0]           r_e1_p;
    logic [ssa_pkg::CORR_W-1:0]        r_e1_corr;
    logic [ssa_pkg::N_W-1:0]           r_e1_n;
    ssa_pkg::t_side                    r_e1_side;

    logic [61:0]                       pc_prod;
    logic [ssa_pkg::P_W-1:0]           r_e2_p;
    logic [ssa_pkg::P_W-1:0]           r_e2_pc;
    logic [ssa_pkg::N_W-1:0]           r_e2_n;
    ssa_pkg::t_side                    r_e2_side;

    logic [ssa_pkg::P_W-1:0]           e_frac;
    logic [ssa_pkg::P_W-1:0]           e_val;
    logic [ssa_pkg::DEN_W-1:0]         r_e3_den;
    ssa_pkg::t_side                    r_e3_side;

    // Stage handshake
    assign rdy[NST] = i_ready;
    for (genvar k = 0; k < NST; k++) begin : g_rdy
        assign rdy[k] = !r_vld[k] || rdy[k+1];
    end
    assign n_vld   = {r_vld[NST-2:0], i_valid};
    assign o_ready = rdy[0];
    assign o_valid = r_vld[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NST; k++) begin
                if (rdy[k]) begin
                    r_vld[k] <= n_vld[k];
                end
            end
        end
    end

    // Stage 1: table product for the top fraction bits, ln2 slope for the rest
    assign idx       = i_word.u[23 -: ssa_pkg::LUT_ADDR_BITS];
    assign frac_rem  = i_word.u[ssa_pkg::REM_W-1:0];
    assign corr_prod = ssa_pkg::CP_W'(frac_rem) * ssa_pkg::CP_W'(ssa_pkg::LN2_Q30);

    // Stage 2: p * correction
    assign pc_prod = 62'(r_e1_p) * 62'(r_e1_corr);

    // Stage 3: apply correction, shift by the integer part, add one
    always_comb begin
        e_frac = r_e2_p - r_e2_pc;
        e_val  = (r_e2_n >= ssa_pkg::SHIFT_FLUSH) ? '0 : (e_frac >> r_e2_n);
    end

    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            r_e1_p    <= ssa_pkg::EXP2_LUT[idx];
            r_e1_corr <= corr_prod[ssa_pkg::CP_W-1:24];
            r_e1_n    <= i_word.u[ssa_pkg::U_W-1:24];
            r_e1_side <= i_word.side;
        end
        if (rdy[1]) begin
            r_e2_p    <= r_e1_p;
            r_e2_pc   <= pc_prod[60:30];
            r_e2_n    <= r_e1_n;
            r_e2_side <= r_e1_side;
        end
        if (rdy[2]) begin
            r_e3_den  <= ssa_pkg::DEN_W'(ssa_pkg::Q30_ONE) + ssa_pkg::DEN_W'(e_val);
            r_e3_side <= r_e2_side;
        end
    end

    assign o_word.den  = r_e3_den;
    assign o_word.side = r_e3_side;

endmodule

/* hdl/ssa_div.sv */
// Pipelined restoring divider: floor(2^60 / den) and a nonzero-remainder flag.
module ssa_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  ssa_pkg::t_ed_word i_word,
    output logic              o_valid,
    input  logic              i_ready,
    output ssa_pkg::t_dq_word o_word
);

    localparam int NST = ssa_pkg::DIV_STAGES;

    logic [NST-1:0] r_vld;
    logic [NST-1:0] n_vld;
    logic [NST:0]   rdy;

    logic [ssa_pkg::DEN_W-1:0] in_rem  [NST];
    logic [ssa_pkg::Q_W-1:0]   in_quo  [NST];
    logic [ssa_pkg::DEN_W-1:0] in_den  [NST];
    ssa_pkg::t_side            in_side [NST];

    logic [ssa_pkg::DEN_W-1:0] n_rem   [NST];
    logic [ssa_pkg::Q_W-1:0]   n_quo   [NST];
    logic [ssa_pkg::DEN_W-1:0] trial;

    logic [ssa_pkg::DEN_W-1:0] r_rem   [NST];
    logic [ssa_pkg::Q_W-1:0]   r_quo   [NST];
    logic [ssa_pkg::DEN_W-1:0] r_den   [NST];
    ssa_pkg::t_side            r_side  [NST];

    // Stage handshake
    assign rdy[NST] = i_ready;
    for (genvar k = 0; k < NST; k++) begin : g_rdy
        assign rdy[k] = !r_vld[k] || rdy[k+1];
    end
    assign n_vld   = {r_vld[NST-2:0], i_valid};
    assign o_ready = rdy[0];
    assign o_valid = r_vld[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NST; k++) begin
                if (rdy[k]) begin
                    r_vld[k] <= n_vld[k];
                end
            end
        end
    end

    // Stage inputs; the leading numerator bits leave a partial remainder of 2^29
    always_comb begin
        in_rem[0]  = ssa_pkg::DEN_W'(ssa_pkg::Q30_ONE >> 1);
        in_quo[0]  = '0;
        in_den[0]  = i_word.den;
        in_side[0] = i_word.side;
        for (int k = 1; k < NST; k++) begin
            in_rem[k]  = r_rem[k-1];
            in_quo[k]  = r_quo[k-1];
            in_den[k]  = r_den[k-1];
            in_side[k] = r_side[k-1];
        end
    end

    // A few quotient bits per stage: double, compare, subtract
    always_comb begin
        trial = '0;
        for (int k = 0; k < NST; k++) begin
            n_rem[k] = in_rem[k];
            n_quo[k] = in_quo[k];
            for (int j = 0; j < ssa_pkg::DIV_PER_STAGE; j++) begin
                if (k * ssa_pkg::DIV_PER_STAGE + j < ssa_pkg::DIV_STEPS) begin
                    trial = n_rem[k] << 1;
                    if (trial >= in_den[k]) begin
                        n_rem[k] = trial - in_den[k];
                        n_quo[k] = {n_quo[k][ssa_pkg::Q_W-2:0], 1'b1};
                    end else begin
                        n_rem[k] = trial;
                        n_quo[k] = {n_quo[k][ssa_pkg::Q_W-2:0], 1'b0};
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NST; k++) begin
            if (rdy[k]) begin
                r_rem[k]  <= n_rem[k];
                r_quo[k]  <= n_quo[k];
                r_den[k]  <= in_den[k];
                r_side[k] <= in_side[k];
            end
        end
    end

    assign o_word.quo    = r_quo[NST-1];
    assign o_word.rem_nz = |r_rem[NST-1];
    assign o_word.side   = r_side[NST-1];

endmodule

/* hdl/ssa_back.sv */
// Back pipe: sigma, derivative product, rounding and saturation into the output register.
module ssa_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  ssa_pkg::t_dq_word                 i_word,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [ssa_pkg::DATA_W-1:0] o_result,
    output logic                              o_saturated
);

    localparam int NST = 5;

    logic [NST-1:0] r_vld;
    logic [NST-1:0] n_vld;
    logic [NST:0]   rdy;

    logic [ssa_pkg::Q_W-1:0]             n_b1_s;
    logic [ssa_pkg::Q_W-1:0]             r_b1_s;
    ssa_pkg::t_side                      r_b1_side;

    logic [61:0]                         d_prod;
    logic [ssa_pkg::Q_W-1:0]             r_b2_s;
    logic [29:0]                         r_b2_d;
    ssa_pkg::t_side                      r_b2_side;

    logic signed [ssa_pkg::DIFF_W-1:0]   one_minus;
    logic signed [ssa_pkg::B_W-1:0]      b_op;
    logic signed [ssa_pkg::MUL_W-1:0]    n_b3_prod;
    logic signed [ssa_pkg::MUL_W-1:0]    r_b3_prod;
    logic [ssa_pkg::Q_W-1:0]             r_b3_s;
    logic                                r_b3_func;
    logic                                r_b3_special;

    logic signed [ssa_pkg::MUL_W-1:0]    sel_v;
    logic [ssa_pkg::MUL_W-1:0]           n_b4_mag;
    logic [ssa_pkg::MUL_W-1:0]           r_b4_mag;
    logic                                r_b4_neg;
    ssa_pkg::t_rnd                       n_b4_rnd;
    ssa_pkg::t_rnd                       r_b4_rnd;

    logic [ssa_pkg::MUL_W-1:0]           rnd_mag;
    logic                                n_sat;
    logic signed [ssa_pkg::DATA_W-1:0]   n_result;
    logic signed [ssa_pkg::DATA_W-1:0]   r_result;
    logic                                r_saturated;

    // Stage handshake; the last stage is the output register
    assign rdy[NST] = i_ready;
    for (genvar k = 0; k < NST; k++) begin : g_rdy
        assign rdy[k] = !r_vld[k] || rdy[k+1];
    end
    assign n_vld   = {r_vld[NST-2:0], i_valid};
    assign o_ready = rdy[0];
    assign o_valid = r_vld[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NST; k++) begin
                if (rdy[k]) begin
                    r_vld[k] <= n_vld[k];
                end
            end
        end
    end

    // Stage 1: sigma; for z below zero use 1 - ceil(2^60/den) in Q30
    assign n_b1_s = i_word.side.neg
                  ? (ssa_pkg::Q30_ONE - i_word.quo - ssa_pkg::Q_W'(i_word.rem_nz))
                  : i_word.quo;

    // Stage 2: sigma * (1 - sigma)
    assign d_prod = 62'(r_b1_s) * 62'(ssa_pkg::Q30_ONE - r_b1_s);

    // Stage 3: shape * d, or value * (1 - value) in the special mode
    always_comb begin
        one_minus = ssa_pkg::ONE_FX - ssa_pkg::DIFF_W'(r_b2_side.opa);
        if (r_b2_side.special) begin
            b_op = ssa_pkg::B_W'(one_minus);
        end else begin
            b_op = $signed({1'b0, r_b2_d});
        end
        n_b3_prod = $signed(r_b2_side.opa) * b_op;
    end

    // Stage 4: pick the value, take its magnitude, pick the rounding point
    always_comb begin
        if (!r_b3_func) begin
            sel_v    = $signed(ssa_pkg::MUL_W'(r_b3_s));
            n_b4_rnd = ssa_pkg::RND_SIGMA;
        end else if (r_b3_special) begin
            sel_v    = r_b3_prod;
            n_b4_rnd = ssa_pkg::RND_SPECIAL;
        end else begin
            sel_v    = r_b3_prod;
            n_b4_rnd = ssa_pkg::RND_GENERAL;
        end
        n_b4_mag = sel_v[ssa_pkg::MUL_W-1] ? -sel_v : sel_v;
    end

    // Stage 5: round half away from zero, saturate, restore sign
    always_comb begin
        unique case (r_b4_rnd)
            ssa_pkg::RND_SIGMA:   rnd_mag = (r_b4_mag + ssa_pkg::HALF_SIG) >> ssa_pkg::RS_SIG;
            ssa_pkg::RND_SPECIAL: rnd_mag = (r_b4_mag + ssa_pkg::HALF_SPC) >> ssa_pkg::RS_SPC;
            ssa_pkg::RND_GENERAL: rnd_mag = (r_b4_mag + ssa_pkg::HALF_GEN) >> ssa_pkg::RS_GEN;
            default:              rnd_mag = '0;
        endcase
        n_sat = r_b4_neg ? (rnd_mag > ssa_pkg::MAG_NEG_LIMIT)
                         : (rnd_mag > ssa_pkg::MAG_POS_LIMIT);
        if (n_sat) begin
            n_result = r_b4_neg ? ssa_pkg::RES_MIN : ssa_pkg::RES_MAX;
        end else if (r_b4_neg) begin
            n_result = -$signed(rnd_mag[ssa_pkg::DATA_W-1:0]);
        end else begin
            n_result = $signed(rnd_mag[ssa_pkg::DATA_W-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            r_b1_s    <= n_b1_s;
            r_b1_side <= i_word.side;
        end
        if (rdy[1]) begin
            r_b2_s    <= r_b1_s;
            r_b2_d    <= d_prod[59:30];
            r_b2_side <= r_b1_side;
        end
        if (rdy[2]) begin
            r_b3_prod    <= n_b3_prod;
            r_b3_s       <= r_b2_s;
            r_b3_func    <= r_b2_side.func;
            r_b3_special <= r_b2_side.special;
        end
        if (rdy[3]) begin
            r_b4_mag <= n_b4_mag;
            r_b4_neg <= sel_v[ssa_pkg::MUL_W-1];
            r_b4_rnd <= n_b4_rnd;
        end
        if (rdy[4]) begin
            r_result    <= n_result;
            r_saturated <= n_sat;
        end
    end

    assign o_result    = r_result;
    assign o_saturated = r_saturated;

endmodule

/* hdl/shaped_sigmoid_activation_unit.sv */
// Top level of the shaped sigmoid unit: configuration registers and the four pipe sections.
//
//   Channel | Ports                              | Moves
//   --------+------------------------------------+--------------------------------------
//   input   | i_in_valid / o_in_ready            | word: i_func, i_value
//   output  | o_out_valid / i_out_ready          | word: o_result, o_saturated
//   config  | i_cfg_wen, i_cfg_idx, i_cfg_wdata  | register write, no wait, no read-back
//
// One word per cycle sustained while the receiver takes every result; stages: front 4, exp2 3, divider 8, back 5;
// the eight-stage divider retires four quotient bits per stage, three in its last stage.
// Reset clears every stage valid bit and loads shape 1.0, range 0..1.0.
// Each stage holds its word while the next one is full and stalled; empty stages
// keep filling, so a waiting output word does not block intake until the pipe is full.
module shaped_sigmoid_activation_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_func,
    input  logic signed [ssa_pkg::DATA_W-1:0]    i_value,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [ssa_pkg::DATA_W-1:0]    o_result,
    output logic                                o_saturated,
    input  logic                                i_cfg_wen,
    input  logic [ssa_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [ssa_pkg::DATA_W-1:0]          i_cfg_wdata
);

    logic signed [ssa_pkg::DATA_W-1:0] r_shape_gain;
    logic signed [ssa_pkg::DATA_W-1:0] r_range_min;
    logic signed [ssa_pkg::DATA_W-1:0] r_range_max;

    logic              fe_valid;
    logic              fe_ready;
    ssa_pkg::t_fe_word fe_word;
    logic              ed_valid;
    logic              ed_ready;
    ssa_pkg::t_ed_word ed_word;
    logic              dq_valid;
    logic              dq_ready;
    ssa_pkg::t_dq_word dq_word;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shape_gain <= ssa_pkg::SHAPE_GAIN_RESET;
            r_range_min  <= ssa_pkg::RANGE_MIN_RESET;
            r_range_max  <= ssa_pkg::RANGE_MAX_RESET;
        end else if (i_cfg_wen) begin
            unique case (i_cfg_idx)
                ssa_pkg::CFG_SHAPE_GAIN: r_shape_gain <= $signed(i_cfg_wdata);
                ssa_pkg::CFG_RANGE_MIN:  r_range_min  <= $signed(i_cfg_wdata);
                ssa_pkg::CFG_RANGE_MAX:  r_range_max  <= $signed(i_cfg_wdata);
                default: ;
            endcase
        end
    end

    // Centering, shape multiply, log2(e) scaling
    ssa_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .o_ready      (o_in_ready),
        .i_func       (i_func),
        .i_value      (i_value),
        .i_shape_gain (r_shape_gain),
        .i_range_min  (r_range_min),
        .i_range_max  (r_range_max),
        .o_valid      (fe_valid),
        .i_ready      (fe_ready),
        .o_word       (fe_word)
    );

    // 1 + 2^-u
    ssa_exp2 u_exp2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fe_valid),
        .o_ready (fe_ready),
        .i_word  (fe_word),
        .o_valid (ed_valid),
        .i_ready (ed_ready),
        .o_word  (ed_word)
    );

    // Reciprocal by long division
    ssa_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (ed_valid),
        .o_ready (ed_ready),
        .i_word  (ed_word),
        .o_valid (dq_valid),
        .i_ready (dq_ready),
        .o_word  (dq_word)
    );

    // Sigma, derivative, rounding, output register
    ssa_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (dq_valid),
        .o_ready     (dq_ready),
        .i_word      (dq_word),
        .o_valid     (o_out_valid),
        .i_ready     (i_out_ready),
        .o_result    (o_result),
        .o_saturated (o_saturated)
    );

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the shaped sigmoid unit: directed cases, random sweeps, back-pressure.
module testbench;

    // Fixed-point constants of the predictor
    localparam longint unsigned UNIT_FX30  = 64'd1 << 30;
    localparam longint unsigned LOG2E_FX30 = 64'd1549082005;
    localparam longint unsigned LN2_FX30   = 64'd744261118;
    localparam int              PROD_FRAC  = 2 * ssa_pkg::FRAC_BITS + 1;
    localparam longint unsigned Z_CAP      = 64'd32 << PROD_FRAC;
    localparam longint          WORD_ONE   = longint'(1) << ssa_pkg::FRAC_BITS;
    localparam longint          TOP_POS    = 8388607;
    localparam longint          TOP_NEG    = -8388608;
    localparam logic [ssa_pkg::DATA_W-1:0] WORD_MAX = 24'h7FFFFF;
    localparam logic [ssa_pkg::DATA_W-1:0] WORD_MIN = 24'h800000;
    localparam logic [ssa_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int              STALL_LIMIT = 1000;

    typedef struct packed {
        logic signed [ssa_pkg::DATA_W-1:0] result;
        logic                              saturated;
    } t_activation_word;

    typedef enum int {
        RX_STEADY,
        RX_RANDOM,
        RX_COMB
    } t_rx_mode;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              in_valid = 1'b0;
    logic                              in_ready;
    logic                              in_func = 1'b0;
    logic signed [ssa_pkg::DATA_W-1:0] in_value = '0;
    logic                              out_valid;
    logic                              out_ready = 1'b0;
    logic signed [ssa_pkg::DATA_W-1:0] out_result;
    logic                              out_saturated;
    logic                              cfg_wen = 1'b0;
    logic [ssa_pkg::CFG_IDX_W-1:0]     cfg_idx = '0;
    logic [ssa_pkg::DATA_W-1:0]        cfg_wdata = '0;

    // Register copy used for prediction
    logic signed [ssa_pkg::DATA_W-1:0] gain_q = ssa_pkg::SHAPE_GAIN_RESET;
    logic signed [ssa_pkg::DATA_W-1:0] range_lo_q = ssa_pkg::RANGE_MIN_RESET;
    logic signed [ssa_pkg::DATA_W-1:0] range_hi_q = ssa_pkg::RANGE_MAX_RESET;

    t_activation_word pending_activations[$];
    int error_count = 0;
    int burst_left = 0;
    int hold_request = 0;

    shaped_sigmoid_activation_unit uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_func      (in_func),
        .i_value     (in_value),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_result    (out_result),
        .o_saturated (out_saturated),
        .i_cfg_wen   (cfg_wen),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // ---------------------------------------------------------------- predictor

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned rest, root, b;
        rest = v;
        root = 0;
        b = 64'd1 << 62;
        while (b > rest) b = b >> 2;
        while (b != 0) begin
            if (rest >= root + b) begin
                rest = rest - (root + b);
                root = (root >> 1) + b;
            end else begin
                root = root >> 1;
            end
            b = b >> 2;
        end
        return root;
    endfunction

    // 2^-f for f in Q24 [0,1), Q30 result: table product times linear correction
    function automatic longint unsigned exp2_neg_frac(input longint unsigned f);
        longint unsigned sel, rem, p, c, corr;
        sel = f >> (24 - ssa_pkg::LUT_ADDR_BITS);
        rem = f & ((64'd1 << (24 - ssa_pkg::LUT_ADDR_BITS)) - 1);
        p = UNIT_FX30;
        c = UNIT_FX30 >> 1;
        for (int j = 1; j <= ssa_pkg::LUT_ADDR_BITS; j++) begin
            c = int_sqrt(c << 30);
            if (((sel >> (ssa_pkg::LUT_ADDR_BITS - j)) & 1) != 0) p = (p * c) >> 30;
        end
        corr = (rem * LN2_FX30) >> 24;
        return p - ((p * corr) >> 30);
    endfunction

    // Logistic of z (PROD_FRAC fraction bits), Q30 result
    function automatic longint unsigned sigmoid_q30(input longint z);
        longint unsigned a, u, n, e;
        if (z < 0) a = -z;
        else a = z;
        if (a > Z_CAP) a = Z_CAP;
        if (PROD_FRAC >= 24) a = a >> (PROD_FRAC - 24);
        else a = a << (24 - PROD_FRAC);
        u = (a * LOG2E_FX30) >> 30;
        n = u >> 24;
        e = (n >= 31) ? 64'd0 : (exp2_neg_frac(u & 64'hFFFFFF) >> n);
        if (z < 0) return (e << 30) / (UNIT_FX30 + e);
        return (64'd1 << 60) / (UNIT_FX30 + e);
    endfunction

    // Round half away from zero, then clamp to the word range
    function automatic t_activation_word round_saturate(input longint v, input int sh);
        t_activation_word w;
        longint unsigned mag;
        longint r;
        if (v < 0) mag = -v;
        else mag = v;
        mag = (mag + (64'd1 << (sh - 1))) >> sh;
        if (mag > (64'd1 << 40)) mag = 64'd1 << 40;
        r = (v < 0) ? -longint'(mag) : longint'(mag);
        w.saturated = 1'b0;
        if (r > TOP_POS) begin
            r = TOP_POS;
            w.saturated = 1'b1;
        end
        if (r < TOP_NEG) begin
            r = TOP_NEG;
            w.saturated = 1'b1;
        end
        w.result = r[ssa_pkg::DATA_W-1:0];
        return w;
    endfunction

    function automatic t_activation_word predict_activation(
            input logic f, input logic signed [ssa_pkg::DATA_W-1:0] v);
        longint shp, lo, hi, x, z;
        longint unsigned s, d;
        shp = gain_q;
        lo = range_lo_q;
        hi = range_hi_q;
        x = v;
        z = shp * (2 * x - (lo + hi));
        if (!f) begin
            s = sigmoid_q30(z);
            return round_saturate(longint'(s), 30 - ssa_pkg::FRAC_BITS);
        end
        // derivative of a previous output when range is -1..1 at unit shape
        if (lo == -WORD_ONE && hi == WORD_ONE && shp == WORD_ONE)
            return round_saturate(x * (WORD_ONE - x), ssa_pkg::FRAC_BITS);
        s = sigmoid_q30(z);
        d = (s * (UNIT_FX30 - s)) >> 30;
        return round_saturate(shp * longint'(d), 30);
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    function automatic logic [ssa_pkg::DATA_W-1:0] clip_word(input longint v);
        if (v > TOP_POS) return WORD_MAX;
        if (v < TOP_NEG) return WORD_MIN;
        return v[ssa_pkg::DATA_W-1:0];
    endfunction

    function automatic logic [ssa_pkg::DATA_W-1:0] random_setting();
        int k;
        k = $urandom_range(0, 9);
        if (k == 0) return WORD_MAX;
        if (k == 1) return WORD_MIN;
        if (k == 2) return '0;
        if (k <= 5) return clip_word(longint'($urandom_range(0, 8 * WORD_ONE)) - 4 * WORD_ONE);
        if (k <= 7) return clip_word(longint'($urandom_range(0, 64)) - 32);
        return ssa_pkg::DATA_W'($urandom);
    endfunction

    // Values spread over the word, around the center, and across the steep part of the curve
    function automatic logic [ssa_pkg::DATA_W-1:0] random_value();
        longint mid, span, mag;
        mid = (longint'(range_lo_q) + longint'(range_hi_q)) / 2;
        case ($urandom_range(0, 3))
            0: return ssa_pkg::DATA_W'($urandom);
            1: return clip_word(mid + longint'($urandom_range(0, 8 * WORD_ONE)) - 4 * WORD_ONE);
            2: return clip_word(longint'($urandom_range(0, 3 * WORD_ONE)) - WORD_ONE);
            default: begin
                mag = (gain_q < 0) ? -longint'(gain_q) : longint'(gain_q);
                span = (mag == 0) ? 4 * WORD_ONE : (8 * WORD_ONE * WORD_ONE) / mag + 1;
                if (span > (longint'(1) << 24)) span = longint'(1) << 24;
                return clip_word(mid + (longint'($urandom) % (2 * span + 1)) - span);
            end
        endcase
    endfunction

    // ---------------------------------------------------------------- drivers

    task automatic report_mismatch(input string what, input longint want, input longint got);
        error_count++;
        if (error_count <= 40) $display("mismatch %s: expected %0d got %0d", what, want, got);
    endtask

    // Offer one word, hold it until taken, then keep going or pause between bursts
    task automatic send_word(input logic f, input logic [ssa_pkg::DATA_W-1:0] v);
        int gap;
        in_valid <= 1'b1;
        in_func  <= f;
        in_value <= v;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        pending_activations.push_back(predict_activation(f, v));
        @(negedge clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80)
                                                     : $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
    endtask

    // Drop valid and wait until every pending word has come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_activations.size() != 0) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_register(input logic [ssa_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [ssa_pkg::DATA_W-1:0] data);
        cfg_wen   <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= data;
        @(negedge clk);
        cfg_wen <= 1'b0;
        case (idx)
            ssa_pkg::CFG_SHAPE_GAIN: gain_q = data;
            ssa_pkg::CFG_RANGE_MIN:  range_lo_q = data;
            ssa_pkg::CFG_RANGE_MAX:  range_hi_q = data;
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic set_range(input logic [ssa_pkg::DATA_W-1:0] shp,
                             input logic [ssa_pkg::DATA_W-1:0] lo,
                             input logic [ssa_pkg::DATA_W-1:0] hi);
        write_register(ssa_pkg::CFG_SHAPE_GAIN, shp);
        write_register(ssa_pkg::CFG_RANGE_MIN, lo);
        write_register(ssa_pkg::CFG_RANGE_MAX, hi);
    endtask

    // ---------------------------------------------------------------- tests

    // Reset settings: shape 1.0, range 0..1.0
    task automatic test_reset_defaults();
        send_word(1'b0, ssa_pkg::DATA_W'(WORD_ONE / 2));
        send_word(1'b0, WORD_MIN);
        send_word(1'b0, WORD_MAX);
        send_word(1'b0, '0);
        send_word(1'b0, ssa_pkg::DATA_W'(WORD_ONE));
        send_word(1'b1, ssa_pkg::DATA_W'(WORD_ONE / 2));
        send_word(1'b1, WORD_MIN);
        send_word(1'b1, WORD_MAX);
        wait_drained();
    endtask

    // Range -1..1 at unit shape: derivative takes v*(1-v), sigmoid stays general
    task automatic test_unit_range();
        set_range(ssa_pkg::DATA_W'(WORD_ONE), ssa_pkg::DATA_W'(-WORD_ONE),
                  ssa_pkg::DATA_W'(WORD_ONE));
        send_word(1'b1, '0);
        send_word(1'b1, ssa_pkg::DATA_W'(WORD_ONE / 2));
        send_word(1'b1, ssa_pkg::DATA_W'(WORD_ONE));
        send_word(1'b1, ssa_pkg::DATA_W'(-WORD_ONE));
        send_word(1'b1, WORD_MIN);
        send_word(1'b1, WORD_MAX);
        send_word(1'b0, '0);
        send_word(1'b0, WORD_MAX);
        wait_drained();
        // one LSB off unit shape falls back to the general derivative
        write_register(ssa_pkg::CFG_SHAPE_GAIN, ssa_pkg::DATA_W'(WORD_ONE + 1));
        send_word(1'b1, ssa_pkg::DATA_W'(WORD_ONE / 2));
        wait_drained();
    endtask

    // A write to the spare index must change nothing
    task automatic test_unused_index();
        write_register(ssa_pkg::CFG_SHAPE_GAIN, ssa_pkg::DATA_W'(WORD_ONE));
        write_register(CFG_UNUSED, ssa_pkg::DATA_W'($urandom));
        send_word(1'b1, ssa_pkg::DATA_W'(WORD_ONE / 4));
        send_word(1'b0, ssa_pkg::DATA_W'(WORD_ONE / 4));
        wait_drained();
    endtask

    task automatic test_extreme_config();
        set_range(WORD_MIN, WORD_MIN, WORD_MAX);
        send_word(1'b0, '0);
        send_word(1'b1, '0);
        send_word(1'b1, WORD_MAX);
        send_word(1'b0, WORD_MIN);
        wait_drained();
        set_range(WORD_MAX, WORD_MAX, WORD_MAX);
        send_word(1'b0, WORD_MIN);
        send_word(1'b1, WORD_MAX);
        wait_drained();
        set_range('0, WORD_MIN, '0);
        send_word(1'b1, 24'h123456);
        send_word(1'b0, 24'hEDCBA9);
        wait_drained();
    endtask

    // Stop the receiver for a long stretch while words keep coming; the pipe must fill
    task automatic test_back_pressure();
        set_range(ssa_pkg::DATA_W'(WORD_ONE * 2), ssa_pkg::DATA_W'(-WORD_ONE),
                  ssa_pkg::DATA_W'(WORD_ONE * 3));
        hold_request = 150;
        repeat (60) send_word(1'($urandom_range(0, 1)), random_value());
        wait_drained();
    endtask

    task automatic test_random_sweep();
        for (int phase = 0; phase < 12; phase++) begin
            if (phase % 4 == 1)
                set_range(ssa_pkg::DATA_W'(WORD_ONE), ssa_pkg::DATA_W'(-WORD_ONE),
                          ssa_pkg::DATA_W'(WORD_ONE));
            else
                set_range(random_setting(), random_setting(), random_setting());
            repeat (125) send_word(1'($urandom_range(0, 1)), random_value());
            wait_drained();
        end
    endtask

    // ---------------------------------------------------------------- receiver and checks

    // Receiver: switch between steady, random and comb-like stall patterns
    initial begin
        t_rx_mode mode;
        int left;
        int hold;
        int tick;
        mode = RX_STEADY;
        left = 0;
        hold = 0;
        tick = 0;
        forever begin
            @(negedge clk);
            tick++;
            if (hold_request > 0) begin
                hold = hold_request;
                hold_request = 0;
            end
            if (left == 0) begin
                mode = t_rx_mode'($urandom_range(0, 2));
                left = $urandom_range(8, 80);
            end
            left--;
            if (hold > 0) begin
                hold--;
                out_ready <= 1'b0;
            end else begin
                case (mode)
                    RX_STEADY: out_ready <= 1'b1;
                    RX_RANDOM: out_ready <= ($urandom_range(0, 2) != 0);
                    default:   out_ready <= (tick % 4 != 3);
                endcase
            end
        end
    end

    // Compare every returned word with the oldest prediction
    always @(posedge clk) begin
        t_activation_word want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_activations.size() == 0) begin
                report_mismatch("result with nothing pending", 0, out_result);
            end else begin
                want = pending_activations.pop_front();
                if (out_result !== want.result)
                    report_mismatch("result", want.result, out_result);
                if (out_saturated !== want.saturated)
                    report_mismatch("saturated", want.saturated, out_saturated);
            end
        end
    end

    // Abort when neither channel moves a word for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
            else quiet++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_reset_defaults();
        test_unit_range();
        test_unused_index();
        test_extreme_config();
        test_back_pressure();
        test_random_sweep();
        wait_drained();
        repeat (30) @(negedge clk);
        if (error_count == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end

endmodule
